// ===== sv/mcr_pkg.sv =====
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int COORD_BITS = 10;
  localparam int OFF_W      = COORD_BITS + 2;
  localparam int DEC_W      = COORD_BITS + 6;
  localparam int PIX_W      = 12;
  localparam int FIELD_W    = 10;
  localparam int QDEPTH     = 2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] center_x;
    logic [FIELD_W-1:0] center_y;
    logic [FIELD_W-1:0] circle_radius;
  } cmd_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last_of_step;
    logic                    circle_done;
  } pix_t;

  // one octant point with its centre, expanded into eight pixels by the back end
  typedef struct packed {
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic signed [OFF_W-1:0] x;
    logic signed [OFF_W-1:0] y;
    logic                    done;
  } grp_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

// ===== sv/midpoint_circle_rasterizer_core.sv =====
// The back end emits one pixel per cycle, eight per start or live step, from its
//   single-pixel output register, while pix_stall is low and a group is queued;
//   a step with no circle is taken and pushes nothing into the queue.
// A two-entry queue between command decode and pixel expansion keeps commands flowing.
// Reset (rst, synchronous) clears the circle state, the queue and the output valid.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  mcr_pkg::cmd_t cmd,
  output logic          pix_valid,
  input  logic          pix_stall,
  output mcr_pkg::pix_t pix
);

  mcr_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  mcr_pkg::grp_t      push_grp;
  mcr_pkg::grp_t      pop_grp;

  mcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_status  (q_status),
    .push      (push),
    .push_grp  (push_grp)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .pop_grp  (pop_grp),
    .status   (q_status)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_grp   (pop_grp),
    .pop       (pop),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule

// ===== sv/mcr_front.sv =====
`timescale 1ns / 1ps

module mcr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  mcr_pkg::cmd_t       cmd,
  input  mcr_pkg::q_status_t  q_status,
  output logic                push,
  output mcr_pkg::grp_t       push_grp
);

  logic                                    active;
  logic [mcr_pkg::COORD_BITS-1:0]          saved_center_x;
  logic [mcr_pkg::COORD_BITS-1:0]          saved_center_y;
  logic signed [mcr_pkg::OFF_W-1:0]        offset_x;
  logic signed [mcr_pkg::OFF_W-1:0]        offset_y;
  logic signed [mcr_pkg::DEC_W-1:0]        decision;

  logic                                    accept;
  logic [mcr_pkg::COORD_BITS-1:0]          r_in;
  logic signed [mcr_pkg::OFF_W-1:0]        xn;
  logic signed [mcr_pkg::OFF_W-1:0]        yn;
  logic signed [mcr_pkg::DEC_W-1:0]        xn_w;
  logic signed [mcr_pkg::DEC_W-1:0]        yn_w;
  logic signed [mcr_pkg::DEC_W-1:0]        dn;
  logic signed [mcr_pkg::DEC_W-1:0]        d_start;
  logic                                    d_pos;
  logic                                    step_done;

  assign cmd_stall = q_status.full;
  assign accept    = cmd_valid && !q_status.full;
  assign r_in      = mcr_pkg::COORD_BITS'(cmd.circle_radius);

  assign d_pos = !decision[mcr_pkg::DEC_W-1] && (decision != '0);

  always_comb begin
    xn = offset_x + mcr_pkg::OFF_W'(1);
    yn = d_pos ? offset_y - mcr_pkg::OFF_W'(1) : offset_y;
    xn_w = mcr_pkg::DEC_W'(xn);
    yn_w = mcr_pkg::DEC_W'(yn);
    if (d_pos) begin
      dn = decision + ((xn_w - yn_w) <<< 2) + mcr_pkg::DEC_W'(10);
    end else begin
      dn = decision + (xn_w <<< 2) + mcr_pkg::DEC_W'(6);
    end
    d_start   = mcr_pkg::DEC_W'(3) - (mcr_pkg::DEC_W'(r_in) << 1);
    step_done = yn < xn;
  end

  // a step with no circle in progress is taken and dropped
  always_comb begin
    push     = 1'b0;
    push_grp = '0;
    if (accept) begin
      unique case (cmd.cmd)
        mcr_pkg::CMD_START: begin
          push          = 1'b1;
          push_grp.cx   = mcr_pkg::COORD_BITS'(cmd.center_x);
          push_grp.cy   = mcr_pkg::COORD_BITS'(cmd.center_y);
          push_grp.x    = '0;
          push_grp.y    = mcr_pkg::OFF_W'(r_in);
          push_grp.done = 1'b0;
        end
        mcr_pkg::CMD_STEP: begin
          push          = active;
          push_grp.cx   = saved_center_x;
          push_grp.cy   = saved_center_y;
          push_grp.x    = xn;
          push_grp.y    = yn;
          push_grp.done = step_done;
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      saved_center_x <= '0;
      saved_center_y <= '0;
      offset_x       <= '0;
      offset_y       <= '0;
      decision       <= '0;
    end else if (accept) begin
      if (cmd.cmd == mcr_pkg::CMD_START) begin
        active         <= 1'b1;
        saved_center_x <= mcr_pkg::COORD_BITS'(cmd.center_x);
        saved_center_y <= mcr_pkg::COORD_BITS'(cmd.center_y);
        offset_x       <= '0;
        offset_y       <= mcr_pkg::OFF_W'(r_in);
        decision       <= d_start;
      end else if (active) begin
        offset_x <= xn;
        offset_y <= yn;
        decision <= dn;
        active   <= !step_done;
      end
    end
  end

endmodule

// ===== sv/mcr_queue.sv =====
`timescale 1ns / 1ps

module mcr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mcr_pkg::grp_t      push_grp,
  input  logic               pop,
  output mcr_pkg::grp_t      pop_grp,
  output mcr_pkg::q_status_t status
);

  localparam int PTR_W = (mcr_pkg::QDEPTH > 1) ? $clog2(mcr_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(mcr_pkg::QDEPTH + 1);

  mcr_pkg::grp_t    mem [mcr_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(mcr_pkg::QDEPTH));
  assign status.valid = (count != '0);
  assign pop_grp      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mcr_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mcr_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.valid)
    else $error("pop from empty queue");

endmodule

// ===== sv/mcr_back.sv =====
`timescale 1ns / 1ps

module mcr_back (
  input  logic               clk,
  input  logic               rst,
  input  mcr_pkg::q_status_t q_status,
  input  mcr_pkg::grp_t      pop_grp,
  output logic               pop,
  output logic               pix_valid,
  input  logic               pix_stall,
  output mcr_pkg::pix_t      pix
);

  mcr_pkg::grp_t                    cur;
  logic                             cur_valid;
  logic [2:0]                       idx;

  logic                             out_free;
  logic                             cur_take;
  logic                             last;
  logic signed [mcr_pkg::OFF_W-1:0] a;
  logic signed [mcr_pkg::OFF_W-1:0] b;
  logic [mcr_pkg::PIX_W-1:0]        cx_w;
  logic [mcr_pkg::PIX_W-1:0]        cy_w;
  logic [mcr_pkg::PIX_W-1:0]        a_w;
  logic [mcr_pkg::PIX_W-1:0]        b_w;
  mcr_pkg::pix_t                    pix_next;

  assign out_free = !pix_valid || !pix_stall;
  assign last     = (idx == 3'd7);
  assign cur_take = !cur_valid || (out_free && last);
  assign pop      = cur_take && q_status.valid;

  // idx[2] swaps the axes, idx[0] negates the column term, idx[1] the row term
  always_comb begin
    a    = idx[2] ? cur.y : cur.x;
    b    = idx[2] ? cur.x : cur.y;
    cx_w = mcr_pkg::PIX_W'(cur.cx);
    cy_w = mcr_pkg::PIX_W'(cur.cy);
    a_w  = mcr_pkg::PIX_W'(a);
    b_w  = mcr_pkg::PIX_W'(b);
    pix_next.pixel_x      = idx[0] ? cx_w - a_w : cx_w + a_w;
    pix_next.pixel_y      = idx[1] ? cy_w - b_w : cy_w + b_w;
    pix_next.last_of_step = last;
    pix_next.circle_done  = last && cur.done;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_grp;
    end
    if (out_free && cur_valid) begin
      pix <= pix_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      pix_valid <= 1'b0;
    end else begin
      if (out_free) begin
        pix_valid <= cur_valid;
        if (cur_valid) begin
          idx <= idx + 3'd1;
        end
      end
      if (cur_take) begin
        cur_valid <= q_status.valid;
      end
    end
  end

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> idx == 3'd0)
    else $error("pixel index not at zero while no group is held");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.circle_done |-> pix.last_of_step)
    else $error("circle_done outside the last pixel of a group");

  a_reload_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && $past(cur_valid) && cur_valid |-> last && out_free)
    else $error("group replaced before its eighth pixel");

endmodule
